FILE: rtl/core/absolute_to_relative_mouse_events_core_macros.svh
// Assertion macros for the mouse event core checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ABSOLUTE_TO_RELATIVE_MOUSE_EVENTS_CORE_MACROS_SVH
`define ABSOLUTE_TO_RELATIVE_MOUSE_EVENTS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define A2RM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define A2RM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/a2rm_pkg.sv
// Shared types and constants for the mouse event core.
// No dependencies; the front end, queue, back end, top level and checker import this package.
package a2rm_pkg;

    localparam int BUTTON_LINES = 3;
    localparam logic [BUTTON_LINES-1:0] BUTTON_MASK = 3'h7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_MOTION  = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Classified poll: bit 0 of ev_mask is motion, bit i is button i.
    typedef struct packed {
        logic signed [15:0]      dx;
        logic signed [15:0]      dy;
        logic [BUTTON_LINES-1:0] btn_now;
        logic [BUTTON_LINES:0]   ev_mask;
    } a2rm_rec_t;

    typedef struct packed {
        logic      valid;
        a2rm_rec_t rec;
    } a2rm_entry_t;

endpackage

FILE: rtl/core/a2rm_if.sv
// Handshake interfaces for the poll input and the event output.
// Depends on nothing; the core's top level uses both.
interface a2rm_poll_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [2:0]         button_bits;

    modport source (output valid, pos_x, pos_y, button_bits, input ready);
    modport sink (input valid, pos_x, pos_y, button_bits, output ready);
endinterface

interface a2rm_event_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [1:0]         button_number;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               last_event;

    modport source (output valid, event_kind, button_number, delta_x, delta_y, last_event,
                    input ready);
    modport sink (input valid, event_kind, button_number, delta_x, delta_y, last_event,
                  output ready);
endinterface

FILE: rtl/core/a2rm_front.sv
// Front end: accepts polls, forms deltas and button change masks, keeps poll state.
// Depends on a2rm_pkg and a2rm_poll_if.
module a2rm_front #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    a2rm_poll_if.sink             poll,
    output a2rm_pkg::a2rm_entry_t push,
    input  logic                  push_ready
);
    import a2rm_pkg::*;

    localparam int ScanCount = (NUM_BUTTONS < BUTTON_LINES) ? NUM_BUTTONS : BUTTON_LINES;

    logic signed [15:0]      last_x_reg, last_x_next;
    logic signed [15:0]      last_y_reg, last_y_next;
    logic [BUTTON_LINES-1:0] last_btn_reg, last_btn_next;
    logic                    first_reg, first_next;

    logic [BUTTON_LINES-1:0] btn;
    logic [BUTTON_LINES-1:0] changed;
    logic signed [15:0]      base_x;
    logic signed [15:0]      base_y;
    logic                    accept;
    a2rm_rec_t               rec;

    always_comb
    begin
        btn     = poll.button_bits & BUTTON_MASK;
        changed = btn ^ last_btn_reg;
        // On the first poll the previous position is the current one.
        base_x  = first_reg ? poll.pos_x : last_x_reg;
        base_y  = first_reg ? poll.pos_y : last_y_reg;

        rec.dx      = poll.pos_x - base_x;
        rec.dy      = poll.pos_y - base_y;
        rec.btn_now = btn;
        rec.ev_mask[0] = (rec.dx != 16'sd0) || (rec.dy != 16'sd0);
        for (int i = 0; i < BUTTON_LINES; i++)
        begin
            rec.ev_mask[i+1] = (i < ScanCount) ? changed[i] : 1'b0;
        end

        poll.ready = push_ready;
        accept     = poll.valid && push_ready;
        push.valid = poll.valid && (|rec.ev_mask);
        push.rec   = rec;

        last_x_next   = accept ? poll.pos_x : last_x_reg;
        last_y_next   = accept ? poll.pos_y : last_y_reg;
        last_btn_next = accept ? btn : last_btn_reg;
        first_next    = accept ? 1'b0 : first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            last_btn_reg <= '0;
            first_reg    <= 1'b1;
        end
        else
        begin
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            last_btn_reg <= last_btn_next;
            first_reg    <= first_next;
        end
    end

endmodule

FILE: rtl/core/a2rm_queue.sv
// Short queue of classified polls between the front and back ends.
// Depends on a2rm_pkg.
module a2rm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  a2rm_pkg::a2rm_entry_t push,
    output logic                  push_ready,
    output a2rm_pkg::a2rm_entry_t head,
    input  logic                  pop
);
    import a2rm_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    a2rm_rec_t       slots_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        push_ready = (count_reg != FullCnt);
        do_push    = push.valid && push_ready;
        do_pop     = pop && (count_reg != '0);
        head.valid = (count_reg != '0);
        head.rec   = slots_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/a2rm_back.sv
// Back end: walks the event mask of the head entry, one event per beat, into
// an output register. Depends on a2rm_pkg and a2rm_event_if.
module a2rm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  a2rm_pkg::a2rm_entry_t head,
    output logic                  pop,
    a2rm_event_if.source          report
);
    import a2rm_pkg::*;

    localparam int IdxW = $clog2(BUTTON_LINES + 1);

    logic [BUTTON_LINES:0] done_reg, done_next;
    logic [BUTTON_LINES:0] pending;
    logic [BUTTON_LINES:0] sel;
    logic [BUTTON_LINES:0] remaining;
    logic [IdxW-1:0]       sel_idx;
    logic [IdxW-1:0]       btn_idx;
    logic                  load;

    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         button_reg, button_next;
    logic signed [15:0] dx_reg, dx_next;
    logic signed [15:0] dy_reg, dy_next;
    logic               last_reg, last_next;

    always_comb
    begin
        pending = head.rec.ev_mask & ~done_reg;
        sel     = pending & (~pending + 1'b1);
        remaining = pending & ~sel;
        sel_idx = '0;
        for (int i = BUTTON_LINES; i >= 0; i--)
        begin
            if (pending[i])
            begin
                sel_idx = IdxW'(i);
            end
        end
        btn_idx = sel_idx - 1'b1;

        load = head.valid && (!valid_reg || report.ready);
        // The entry leaves the queue with its final event.
        pop  = load && (remaining == '0);

        done_next = done_reg;
        if (load)
        begin
            done_next = (remaining == '0) ? '0 : (done_reg | sel);
        end

        valid_next  = load ? 1'b1 : (valid_reg && !report.ready);
        kind_next   = kind_reg;
        button_next = button_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        last_next   = last_reg;
        if (load)
        begin
            if (sel_idx == '0)
            begin
                kind_next = KIND_MOTION;
            end
            else
            begin
                kind_next = head.rec.btn_now[btn_idx] ? KIND_PRESS : KIND_RELEASE;
            end
            button_next = 2'(sel_idx);
            dx_next     = head.rec.dx;
            dy_next     = head.rec.dy;
            last_next   = (remaining == '0);
        end

        report.valid         = valid_reg;
        report.event_kind    = kind_reg;
        report.button_number = button_reg;
        report.delta_x       = dx_reg;
        report.delta_y       = dy_reg;
        report.last_event    = last_reg;
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        button_reg <= button_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

endmodule

FILE: rtl/core/absolute_to_relative_mouse_events_core.sv
// Top level of the mouse event core: front end, queue and back end.
// Depends on a2rm_pkg, a2rm_if, a2rm_front, a2rm_queue and a2rm_back.
//
//   Port    Dir  Handshake     Beat carries
//   poll    in   valid/ready   pos_x, pos_y, button_bits
//   report  out  valid/ready   event_kind, button_number, delta_x, delta_y, last_event
//
// A poll's zero to four events leave one per cycle while report.ready is high,
// each through the back end's single output register; the first event passes
// through a queue slot and then that output register before it is valid.
// Polls keep being taken until two classified polls wait in the queue; a poll
// with no events still needs a free slot before it is taken.
// Reset clears the stored position and buttons and arms the first-poll case.
module absolute_to_relative_mouse_events_core #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    a2rm_poll_if.sink     poll,
    a2rm_event_if.source  report
);
    import a2rm_pkg::*;

    a2rm_entry_t push;
    a2rm_entry_t head;
    logic        push_ready;
    logic        pop;

    a2rm_front #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll),
        .push      (push),
        .push_ready(push_ready)
    );

    a2rm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ready(push_ready),
        .head      (head),
        .pop       (pop)
    );

    a2rm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .report(report)
    );

endmodule

FILE: rtl/core/a2rm_checker.sv
// Port-level checks for the mouse event core, bound to its top level.
// Depends on a2rm_pkg and the assertion macro header.
`include "absolute_to_relative_mouse_events_core_macros.svh"

module a2rm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         event_kind,
    input logic [1:0]         button_number,
    input logic signed [15:0] delta_x,
    input logic signed [15:0] delta_y,
    input logic               last_event
);
    import a2rm_pkg::*;

    // A stalled beat keeps its contents.
    `A2RM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(button_number) && $stable(delta_x) && $stable(delta_y) && $stable(last_event), "stalled event changed")

    `A2RM_ASSERT_SAME(a_kind, out_valid, event_kind == KIND_MOTION || event_kind == KIND_PRESS || event_kind == KIND_RELEASE, "invalid event kind")

    // Motion carries no button and a nonzero delta.
    `A2RM_ASSERT_SAME(a_motion, out_valid && event_kind == KIND_MOTION, button_number == 2'd0 && (delta_x != 16'sd0 || delta_y != 16'sd0), "bad motion event")

    `A2RM_ASSERT_SAME(a_button, out_valid && event_kind != KIND_MOTION, button_number != 2'd0, "button event without a button")

    // Events of one poll follow each other without a gap.
    `A2RM_ASSERT_NEXT(a_burst, out_valid && out_ready && !last_event, out_valid, "gap inside a poll's events")

endmodule

bind absolute_to_relative_mouse_events_core a2rm_checker u_a2rm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (report.valid),
    .out_ready    (report.ready),
    .event_kind   (report.event_kind),
    .button_number(report.button_number),
    .delta_x      (report.delta_x),
    .delta_y      (report.delta_y),
    .last_event   (report.last_event)
);
